// ===== rtl/lfbe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfbe_pkg: shared types and constants of the LED frame brightness encoder
// Word kinds, register indexes and the controller/datapath command and
// status bundles.
// ----------------------------------------------------------------------------
package lfbe_pkg;

    // register indexes on the configuration port
    localparam logic [1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_MAX_LEVEL = 2'd1;
    localparam logic [1:0] CFG_LED_COUNT = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;

    // reset values of the registers
    localparam logic [7:0]  THRESHOLD_RST = 8'd255;
    localparam logic [4:0]  MAX_LEVEL_RST = 5'd31;
    localparam logic [10:0] LED_COUNT_RST = 11'd1;

    // top three bits of the brightness byte of a pixel word
    localparam logic [2:0] FRAME_MARK = 3'b111;

    // one end word per 32 pixels, plus one
    localparam int END_SHIFT = 5;

    // radix-4 divider: 14-bit dividend, two quotient bits per step
    localparam int DIV_STEPS = 7;
    localparam int STEP_W    = 3;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_PIXEL = 2'd1,
        KIND_END   = 2'd2
    } t_word_kind;

    typedef struct packed {
        logic       capture;
        logic       calc;
        logic       load;
        logic       step;
        logic       push;
        t_word_kind kind;
        logic       last;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic pos_zero;
        logic strip_end;
        logic end_last;
    } t_dp_status;

endpackage

// ===== rtl/led_frame_brightness_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_frame_brightness_encoder: LED frame word encoder with global brightness
// Turns RGB pixel items into 32-bit LED strip frame words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one pixel item: red, green,
//   blue. Output channel (o_out_valid / i_out_ready) gives frame words with
//   their kind (start, pixel, end) and a flag on the last word of the item.
//   Configuration channel (i_cfg_valid / o_cfg_ready, always ready) writes
//   threshold (0), max_level (1) and led_count (2); write only while idle.
//   After an item is accepted, the datapath calculates the level, loads the
//   divider and runs 7 steps of the radix-4 divider that rescales the three
//   channels in parallel. Then one word per cycle while the receiver is ready:
//   start word when the strip begins, the pixel word, and led_count/32+1 end
//   words when the strip ends (led_count capped at MAX_LEDS). The next item
//   is taken the cycle after the last word enters the output register.
//   A stalled receiver holds the output register and pauses word issue.
//   Reset restores threshold 255, max_level 31, led_count 1 and moves to the
//   start of a strip.
// ----------------------------------------------------------------------------
module led_frame_brightness_encoder #(
    parameter int MAX_LEDS = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [7:0]                       i_red,
    input  logic [7:0]                       i_green,
    input  logic [7:0]                       i_blue,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [31:0]                      o_out_word,
    output logic [1:0]                       o_word_kind,
    output logic                             o_run_last,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lfbe_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [lfbe_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    lfbe_pkg::t_dp_cmd    s_cmd;
    lfbe_pkg::t_dp_status s_st;

    assign o_cfg_ready = 1'b1;

    lfbe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_st       (s_st),
        .o_cmd      (s_cmd)
    );

    lfbe_datapath #(
        .MAX_LEDS (MAX_LEDS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (s_cmd),
        .o_st        (s_st),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .o_word_kind (o_word_kind),
        .o_run_last  (o_run_last)
    );

    // one item at a time: no second accept right after the first
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("item accepted while another is in work");

    // never overwrite a word the receiver has not taken
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.push |-> s_st.out_free)
        else $error("word pushed into a full output register");

    // no word is issued while waiting for an item
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !s_cmd.push)
        else $error("word pushed while idle");

endmodule

// ===== rtl/lfbe_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfbe_ctrl: sequencer of the LED frame brightness encoder
// Takes one pixel item, runs the datapath through level calculation and
// division, then pushes any start word, the pixel word and any end words one at a time.
// ----------------------------------------------------------------------------
module lfbe_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lfbe_pkg::t_dp_status i_st,
    output lfbe_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CALC  = 7'b0000010,
        S_LOAD  = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_START = 7'b0010000,
        S_PIXEL = 7'b0100000,
        S_END   = 7'b1000000
    } t_state;

    t_state                      r_state;
    t_state                      n_state;
    logic [lfbe_pkg::STEP_W-1:0] r_step;
    logic [lfbe_pkg::STEP_W-1:0] n_step;

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_step     = '0;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                n_step     = r_step + lfbe_pkg::STEP_W'(1);
                if (r_step == lfbe_pkg::STEP_W'(lfbe_pkg::DIV_STEPS - 1)) begin
                    n_state = i_st.pos_zero ? S_START : S_PIXEL;
                end
            end
            S_START: begin
                if (i_st.out_free) begin
                    o_cmd.push = 1'b1;
                    o_cmd.kind = lfbe_pkg::KIND_START;
                    n_state    = S_PIXEL;
                end
            end
            S_PIXEL: begin
                if (i_st.out_free) begin
                    o_cmd.push = 1'b1;
                    o_cmd.kind = lfbe_pkg::KIND_PIXEL;
                    o_cmd.last = !i_st.strip_end;
                    n_state    = i_st.strip_end ? S_END : S_IDLE;
                end
            end
            S_END: begin
                if (i_st.out_free) begin
                    o_cmd.push = 1'b1;
                    o_cmd.kind = lfbe_pkg::KIND_END;
                    o_cmd.last = i_st.end_last;
                    if (i_st.end_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

// ===== rtl/lfbe_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfbe_datapath: arithmetic and storage of the LED frame brightness encoder
// Holds the registers, strip position, end word count, level calculation,
// three radix-4 rounded dividers and the output register.
// ----------------------------------------------------------------------------
module lfbe_datapath #(
    parameter int MAX_LEDS = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lfbe_pkg::t_dp_cmd                   i_cmd,
    output lfbe_pkg::t_dp_status                o_st,
    input  logic [7:0]                          i_red,
    input  logic [7:0]                          i_green,
    input  logic [7:0]                          i_blue,
    input  logic                                i_cfg_valid,
    input  logic [lfbe_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [lfbe_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [31:0]                         o_out_word,
    output logic [1:0]                          o_word_kind,
    output logic                                o_run_last
);

    localparam int CW = $clog2(MAX_LEDS + 1);
    localparam int EW = $clog2(MAX_LEDS / 32 + 2);

    // one restoring division step: shift in one dividend bit
    function automatic logic [5:0] div_bit(input logic [4:0] rem, input logic nb,
                                           input logic [4:0] d);
        logic [5:0] t;
        t = {rem, nb};
        if (t >= {1'b0, d}) begin
            div_bit = {1'b1, 5'(t - {1'b0, d})};
        end else begin
            div_bit = {1'b0, t[4:0]};
        end
    endfunction

    // configuration and control state
    logic [7:0]    r_threshold;
    logic [4:0]    r_max_level;
    logic [10:0]   r_led_count;
    logic [CW-1:0] r_pos;
    logic [EW-1:0] r_end_left;
    logic          r_out_valid;

    // payload
    logic [7:0]  r_rgb [3];
    logic [12:0] r_prod [3];
    logic [13:0] r_num [3];
    logic [4:0]  r_rem [3];
    logic [4:0]  r_level;
    logic [4:0]  r_bright;
    logic        r_use_div;
    logic [31:0] r_out_word;
    lfbe_pkg::t_word_kind r_out_kind;
    logic        r_out_last;

    logic [7:0]    w_max;
    logic [4:0]    w_lvl;
    logic [13:0]   w_bprod;
    logic [4:0]    w_bright;
    logic          w_thr0;
    logic          w_black;
    logic          w_full;
    logic [4:0]    w_level;
    logic [10:0]   w_cnt_raw;
    logic [CW-1:0] w_cnt;
    logic [EW-1:0] w_ends;
    logic          w_strip_end;
    logic [5:0]    w_s1 [3];
    logic [5:0]    w_s2 [3];
    logic [23:0]   w_color;
    logic [31:0]   w_word;
    logic          w_out_free;

    // effective level and count
    assign w_lvl     = (r_max_level == 5'd0) ? 5'd1 : r_max_level;
    assign w_cnt_raw = (r_led_count == 11'd0) ? 11'd1 : r_led_count;
    assign w_cnt     = (w_cnt_raw > 11'(MAX_LEDS)) ? CW'(MAX_LEDS) : CW'(w_cnt_raw);
    assign w_ends    = EW'(w_cnt >> lfbe_pkg::END_SHIFT) + EW'(1);
    assign w_strip_end = (({1'b0, r_pos} + (CW + 1)'(1)) >= {1'b0, w_cnt});

    // level of the pixel
    always_comb begin
        w_max = r_rgb[0];
        if (r_rgb[1] > w_max) w_max = r_rgb[1];
        if (r_rgb[2] > w_max) w_max = r_rgb[2];
    end

    assign w_bprod  = 14'({1'b0, w_max} + 9'd1) * 14'(w_lvl);
    assign w_bright = 5'((w_bprod - 14'd1) >> 8) + 5'd1;
    assign w_thr0   = (r_threshold == 8'd0);
    assign w_black  = (w_max == 8'd0);
    assign w_full   = (w_max >= r_threshold);

    always_comb begin
        priority if (w_thr0) begin
            w_level = w_black ? 5'd0 : w_lvl;
        end else if (w_black) begin
            w_level = 5'd0;
        end else if (w_full) begin
            w_level = w_lvl;
        end else begin
            w_level = w_bright;
        end
    end

    // two quotient bits per channel per step
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_s1[c] = div_bit(r_rem[c], r_num[c][13], r_bright);
            w_s2[c] = div_bit(w_s1[c][4:0], r_num[c][12], r_bright);
        end
    end

    assign w_color = r_use_div ? {r_num[0][7:0], r_num[1][7:0], r_num[2][7:0]}
                               : {r_rgb[0], r_rgb[1], r_rgb[2]};

    always_comb begin
        unique case (i_cmd.kind)
            lfbe_pkg::KIND_PIXEL: w_word = {lfbe_pkg::FRAME_MARK, r_level, w_color};
            lfbe_pkg::KIND_START: w_word = '0;
            lfbe_pkg::KIND_END:   w_word = '0;
            default:              w_word = '0;
        endcase
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= lfbe_pkg::THRESHOLD_RST;
            r_max_level <= lfbe_pkg::MAX_LEVEL_RST;
            r_led_count <= lfbe_pkg::LED_COUNT_RST;
            r_pos       <= '0;
            r_end_left  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    lfbe_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_data[7:0];
                    lfbe_pkg::CFG_MAX_LEVEL: r_max_level <= i_cfg_data[4:0];
                    lfbe_pkg::CFG_LED_COUNT: r_led_count <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
                if (i_cmd.kind == lfbe_pkg::KIND_PIXEL) begin
                    // wrap to strip start after the last pixel
                    r_pos <= w_strip_end ? '0 : r_pos + CW'(1);
                    if (w_strip_end) begin
                        r_end_left <= w_ends;
                    end
                end else if (i_cmd.kind == lfbe_pkg::KIND_END) begin
                    r_end_left <= r_end_left - EW'(1);
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rgb[0] <= i_red;
            r_rgb[1] <= i_green;
            r_rgb[2] <= i_blue;
        end
        if (i_cmd.calc) begin
            r_level   <= w_level;
            r_bright  <= w_bright;
            r_use_div <= !w_thr0 && !w_black && !w_full;
            for (int c = 0; c < 3; c++) begin
                r_prod[c] <= 13'(r_rgb[c]) * 13'(w_lvl);
            end
        end
        if (i_cmd.load) begin
            // add half the divisor for rounding
            for (int c = 0; c < 3; c++) begin
                r_num[c] <= {1'b0, r_prod[c] + 13'(r_bright >> 1)};
                r_rem[c] <= '0;
            end
        end
        if (i_cmd.step) begin
            // dividend shifts out at the top, quotient shifts in at the bottom
            for (int c = 0; c < 3; c++) begin
                r_num[c] <= {r_num[c][11:0], w_s1[c][5], w_s2[c][5]};
                r_rem[c] <= w_s2[c][4:0];
            end
        end
        if (i_cmd.push) begin
            r_out_word <= w_word;
            r_out_kind <= i_cmd.kind;
            r_out_last <= i_cmd.last;
        end
    end

    assign o_st.out_free  = w_out_free;
    assign o_st.pos_zero  = (r_pos == '0);
    assign o_st.strip_end = w_strip_end;
    assign o_st.end_last  = (r_end_left == EW'(1));

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign o_word_kind = r_out_kind;
    assign o_run_last  = r_out_last;

endmodule

// ===== verif/tb_led_frame_brightness_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_frame_brightness_encoder: self-checking bench for the LED frame encoder
// Drives RGB pixel items and register writes into the block. A scoreboard
// class predicts the start, pixel and end words of every strip. Each word that
// leaves the block is compared in order against those predictions.
// ----------------------------------------------------------------------------
module tb_led_frame_brightness_encoder;

    localparam int          LED_LIMIT    = 1024;
    localparam logic [1:0]  CFG_SPARE    = 2'd3;     // index with no register behind it
    localparam int          RANDOM_ITEMS = 180;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          CYCLE_LIMIT  = 1000000;

    typedef struct {
        logic [31:0]          word;
        lfbe_pkg::t_word_kind kind;
        logic                 last;
    } t_frame_word;

    class frame_word_board;
        logic [7:0]  threshold = lfbe_pkg::THRESHOLD_RST;
        logic [4:0]  max_level = lfbe_pkg::MAX_LEVEL_RST;
        logic [10:0] led_count = lfbe_pkg::LED_COUNT_RST;
        int unsigned position  = 0;
        int          failures  = 0;
        t_frame_word pending_words[$];

        function void set_reg(logic [1:0] idx, logic [lfbe_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                lfbe_pkg::CFG_THRESHOLD: threshold = data[7:0];
                lfbe_pkg::CFG_MAX_LEVEL: max_level = data[4:0];
                lfbe_pkg::CFG_LED_COUNT: led_count = data[10:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] rescale(logic [7:0] value, int unsigned lvl, int unsigned bright);
            int unsigned q;
            q = (lvl * value + (bright >> 1)) / bright;
            return q[7:0];
        endfunction

        function logic [31:0] pixel_word(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
            int unsigned lvl;
            int unsigned peak;
            int unsigned bright;
            logic [4:0]  level;
            lvl  = (max_level == 0) ? 1 : max_level;
            peak = red;
            if (green > peak) peak = green;
            if (blue > peak) peak = blue;
            if (threshold == 0) begin
                level = (peak != 0) ? lvl[4:0] : 5'd0;
            end else if (peak == 0) begin
                level = 5'd0;
            end else if (peak >= threshold) begin
                level = lvl[4:0];
            end else begin
                // dim the current, then stretch the channels back up
                bright = ((((peak + 1) * lvl) - 1) >> 8) + 1;
                level  = bright[4:0];
                red    = rescale(red, lvl, bright);
                green  = rescale(green, lvl, bright);
                blue   = rescale(blue, lvl, bright);
            end
            return {lfbe_pkg::FRAME_MARK, level, red, green, blue};
        endfunction

        function void push_word(logic [31:0] word, lfbe_pkg::t_word_kind kind);
            t_frame_word w;
            w.word = word;
            w.kind = kind;
            w.last = 1'b0;
            pending_words.push_back(w);
        endfunction

        function void encode_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
            int unsigned strip_len;
            strip_len = (led_count == 0) ? 1 : led_count;
            if (strip_len > LED_LIMIT) strip_len = LED_LIMIT;
            if (position == 0) push_word(32'd0, lfbe_pkg::KIND_START);
            push_word(pixel_word(red, green, blue), lfbe_pkg::KIND_PIXEL);
            // a count lowered below the position also ends the strip here
            if (position + 1 >= strip_len) begin
                repeat (strip_len / 32 + 1) push_word(32'd0, lfbe_pkg::KIND_END);
                position = 0;
            end else begin
                position = position + 1;
            end
            pending_words[pending_words.size() - 1].last = 1'b1;
        endfunction

        function void report(string msg);
            failures++;
            if (failures <= 10) $display("ERROR at %0t: %s", $realtime, msg);
        endfunction

        function void check_word(logic [31:0] word, logic [1:0] kind, logic last);
            t_frame_word want;
            if (pending_words.size() == 0) begin
                report($sformatf("unexpected word %h kind %0d last %0b", word, kind, last));
                return;
            end
            want = pending_words.pop_front();
            if (word !== want.word || kind !== want.kind || last !== want.last)
                report($sformatf("expected word %h kind %0d last %0b, got %h kind %0d last %0b",
                                 want.word, want.kind, want.last, word, kind, last));
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic [7:0]            red       = '0;
    logic [7:0]            green     = '0;
    logic [7:0]            blue      = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [lfbe_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [lfbe_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                  calm      = 1'b0;
    int                    hold_req  = 0;
    int                    hold_seen = 0;
    int                    hold_left = 0;

    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [31:0]           o_out_word;
    logic [1:0]            o_word_kind;
    logic                  o_run_last;
    logic                  o_cfg_ready;

    frame_word_board board;

    led_frame_brightness_encoder #(
        .MAX_LEDS(LED_LIMIT)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_red       (red),
        .i_green     (green),
        .i_blue      (blue),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (o_out_word),
        .o_word_kind (o_word_kind),
        .o_run_last  (o_run_last),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("CHECK FAILED");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= calm || ($urandom_range(99) >= 6);
        end
    end

    always @(posedge clk) begin
        if (rst_n && o_out_valid && out_ready)
            board.check_word(o_out_word, o_word_kind, o_run_last);
    end

    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        if (!calm && $urandom_range(99) < 6) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        red      <= r;
        green    <= g;
        blue     <= b;
        do @(posedge clk); while (!o_in_ready);
        board.encode_pixel(r, g, b);
    endtask

    // drop valid and hold until every predicted word has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (board.pending_words.size() != 0);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [lfbe_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!o_cfg_ready);
        board.set_reg(idx, data);
    endtask

    function automatic logic [23:0] pick_pixel(logic [7:0] thr);
        logic [7:0] c[3];
        logic [7:0] peak;
        int         mode;
        mode = $urandom_range(9);
        peak = (thr != 0) ? 8'($urandom_range(thr - 1)) : 8'($urandom_range(255));
        for (int i = 0; i < 3; i++) c[i] = 8'($urandom_range(peak));
        c[$urandom_range(2)] = peak;
        case (mode)
            0: return 24'd0;
            1: return 24'hFFFFFF;
            2: return 24'($urandom_range(255)) << (8 * $urandom_range(2));
            3, 4, 5, 6: return {c[0], c[1], c[2]};
            default: return 24'($urandom);
        endcase
    endfunction

    initial begin
        logic [23:0] px;
        int          rand_items;
        int          phase;
        int          n;
        int          pause_at;
        board = new();
        rand_items = 0;
        phase = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults: threshold 255, max level 31, one pixel per strip
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd254, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd254, 8'd1);
        send_pixel(8'd1, 8'd1, 8'd1);
        send_pixel(8'd1, 8'd0, 8'd128);
        send_pixel(8'd0, 8'd0, 8'd255);

        // fixed max-current mode
        wait_drained();
        write_reg(lfbe_pkg::CFG_THRESHOLD, 11'd0);
        cfg_valid <= 1'b0;
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd1);
        send_pixel(8'd200, 8'd17, 8'd3);

        // zero max level acts as one
        wait_drained();
        write_reg(lfbe_pkg::CFG_THRESHOLD, 11'd100);
        write_reg(lfbe_pkg::CFG_MAX_LEVEL, 11'd0);
        cfg_valid <= 1'b0;
        send_pixel(8'd99, 8'd50, 8'd0);
        send_pixel(8'd100, 8'd0, 8'd0);
        send_pixel(8'd5, 8'd5, 8'd5);

        // high data bits are dropped; zero led count acts as one
        wait_drained();
        write_reg(lfbe_pkg::CFG_MAX_LEVEL, 11'h7FF);
        write_reg(lfbe_pkg::CFG_LED_COUNT, 11'd0);
        cfg_valid <= 1'b0;
        send_pixel(8'd10, 8'd20, 8'd30);

        // lower the count under the current position mid-strip
        wait_drained();
        write_reg(lfbe_pkg::CFG_LED_COUNT, 11'd5);
        cfg_valid <= 1'b0;
        send_pixel(8'd30, 8'd60, 8'd90);
        send_pixel(8'd255, 8'd0, 8'd7);
        send_pixel(8'd64, 8'd64, 8'd64);
        wait_drained();
        write_reg(lfbe_pkg::CFG_LED_COUNT, 11'd2);
        write_reg(CFG_SPARE, 11'h5A5);
        cfg_valid <= 1'b0;
        send_pixel(8'd12, 8'd200, 8'd99);
        send_pixel(8'd3, 8'd2, 8'd1);

        while (rand_items < RANDOM_ITEMS) begin
            wait_drained();
            if (phase == 0 || $urandom_range(9) < 7) begin
                case ($urandom_range(3))
                    0: write_reg(lfbe_pkg::CFG_THRESHOLD, 11'd0);
                    1: write_reg(lfbe_pkg::CFG_THRESHOLD, 11'd255);
                    default: write_reg(lfbe_pkg::CFG_THRESHOLD, 11'($urandom_range(2047)));
                endcase
            end
            if (phase == 0 || $urandom_range(9) < 7)
                write_reg(lfbe_pkg::CFG_MAX_LEVEL, ($urandom_range(9) == 0) ? 11'd1 :
                                                   11'($urandom_range(2047)));
            // skipping the count write lets a strip run across phases
            if (phase == 0 || $urandom_range(9) < 6) begin
                case ($urandom_range(9))
                    0: write_reg(lfbe_pkg::CFG_LED_COUNT, 11'($urandom_range(1025, 2047)));
                    1, 2: write_reg(lfbe_pkg::CFG_LED_COUNT, 11'($urandom_range(32, 70)));
                    default: write_reg(lfbe_pkg::CFG_LED_COUNT, 11'($urandom_range(0, 12)));
                endcase
            end
            if ($urandom_range(9) == 0) write_reg(CFG_SPARE, 11'($urandom_range(2047)));
            cfg_valid <= 1'b0;
            calm <= (phase == 3 || phase == 4);
            if (phase == 2) hold_req <= hold_req + 1;
            n = $urandom_range(10, 25);
            pause_at = ($urandom_range(9) < 3) ? $urandom_range(1, n - 1) : n;
            for (int i = 0; i < n; i++) begin
                if (i == pause_at) wait_drained();
                px = pick_pixel(board.threshold);
                send_pixel(px[23:16], px[15:8], px[7:0]);
            end
            rand_items += n;
            phase++;
        end

        wait_drained();
        repeat (40) @(posedge clk);
        if (board.failures == 0 && board.pending_words.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
